/* rtl/core/gpm_pkg.sv */
// Shared types, constants and helpers for the grid plane mesh generator.
// Used by the core, the configuration block, the sequencer and the emitter.
package gpm_pkg;

	localparam int MAX_SIDE = 256;

	localparam int SIDE_W  = 9;
	localparam int COUNT_W = 8;
	localparam int INDEX_W = 16;
	localparam int HALF_W  = 15;
	localparam int STEP_W  = 16;
	localparam int POS_W   = 16;
	localparam int TEX_W   = 17;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [SIDE_W-1:0] SIDE_MIN = SIDE_W'(2);
	localparam logic [SIDE_W-1:0] SIDE_MAX = SIDE_W'(MAX_SIDE);

	// Texture coordinate 1.0 in Q1.16.
	localparam logic [TEX_W-1:0] TEX_ONE = TEX_W'(65536);

	localparam logic KIND_VERTEX   = 1'b0;
	localparam logic KIND_TRIANGLE = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GRID_COLUMNS = 3'd0,
		REG_GRID_ROWS    = 3'd1,
		REG_HALF_WIDTH   = 3'd2,
		REG_HALF_HEIGHT  = 3'd3,
		REG_STEP_X       = 3'd4,
		REG_STEP_Y       = 3'd5,
		REG_STEP_U       = 3'd6,
		REG_STEP_V       = 3'd7
	} cfg_reg_t;

	localparam logic [SIDE_W-1:0] RST_GRID_COLUMNS = SIDE_W'(2);
	localparam logic [SIDE_W-1:0] RST_GRID_ROWS    = SIDE_W'(2);
	localparam logic [HALF_W-1:0] RST_HALF_WIDTH   = HALF_W'(128);
	localparam logic [HALF_W-1:0] RST_HALF_HEIGHT  = HALF_W'(128);
	localparam logic [STEP_W-1:0] RST_STEP_X       = STEP_W'(256);
	localparam logic [STEP_W-1:0] RST_STEP_Y       = STEP_W'(256);
	localparam logic [STEP_W-1:0] RST_STEP_U       = STEP_W'(65535);
	localparam logic [STEP_W-1:0] RST_STEP_V       = STEP_W'(65535);

	// Configuration as seen by the datapath; the sides are already clamped.
	typedef struct packed {
		logic [SIDE_W-1:0] cols;
		logic [SIDE_W-1:0] rows;
		logic [HALF_W-1:0] half_width;
		logic [HALF_W-1:0] half_height;
		logic [STEP_W-1:0] step_x;
		logic [STEP_W-1:0] step_y;
		logic [STEP_W-1:0] step_u;
		logic [STEP_W-1:0] step_v;
	} cfg_t;

	// One accepted tick as held between the sequencer and the emitter.
	typedef struct packed {
		logic               kind;
		logic [COUNT_W-1:0] col;
		logic [COUNT_W-1:0] row;
		logic [INDEX_W-1:0] base;
		logic               pass_end;
		logic               sub;
	} item_t;

	typedef struct packed {
		logic                     kind;
		logic signed [POS_W-1:0]  pos_x;
		logic signed [POS_W-1:0]  pos_y;
		logic [TEX_W-1:0]         tex_u;
		logic [TEX_W-1:0]         tex_v;
		logic [INDEX_W-1:0]       corner_a;
		logic [INDEX_W-1:0]       corner_b;
		logic [INDEX_W-1:0]       corner_c;
		logic                     pass_end;
		logic                     last;
	} result_t;

	function automatic logic [SIDE_W-1:0] eff_side(input logic [SIDE_W-1:0] s);
		logic [SIDE_W-1:0] r;
		r = s;
		if (s < SIDE_MIN) begin
			r = SIDE_MIN;
		end else if (s > SIDE_MAX) begin
			r = SIDE_MAX;
		end
		return r;
	endfunction

endpackage

/* rtl/core/gpm_tick_if.sv */
// Tick channel: valid/ready handshake carrying the restart bit.
// Stands alone; no package dependency.
interface gpm_tick_if;
	logic valid;
	logic ready;
	logic restart;

	modport source (output valid, output restart, input ready);
	modport sink (input valid, input restart, output ready);
endinterface

/* rtl/core/gpm_result_if.sv */
// Result channel: valid/ready handshake carrying one vertex or triangle word.
// Field widths follow the constants in gpm_pkg.
interface gpm_result_if;
	logic                valid;
	logic                ready;
	logic                kind;
	logic signed [15:0]  pos_x;
	logic signed [15:0]  pos_y;
	logic [16:0]         tex_u;
	logic [16:0]         tex_v;
	logic [15:0]         corner_a;
	logic [15:0]         corner_b;
	logic [15:0]         corner_c;
	logic                pass_end;
	logic                last;

	modport source (output valid, output kind, output pos_x, output pos_y,
		output tex_u, output tex_v, output corner_a, output corner_b,
		output corner_c, output pass_end, output last, input ready);
	modport sink (input valid, input kind, input pos_x, input pos_y,
		input tex_u, input tex_v, input corner_a, input corner_b,
		input corner_c, input pass_end, input last, output ready);
endinterface

/* rtl/core/grid_plane_mesh_generator_core.sv */
// Grid plane mesh generator: one vertex per tick, then two triangles per quad tick.
// Each accepted tick is held in the stage-1 item register, each word in the output register.
// One word per cycle unless result.ready stalls; the next tick is taken as the last word leaves.
// Reset clears the walk to the first vertex and loads the default register values.
// Depends on gpm_pkg, gpm_tick_if, gpm_result_if and the gpm_* submodules.
module grid_plane_mesh_generator_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [gpm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [gpm_pkg::CFG_DATA_W-1:0] cfg_data,
	gpm_tick_if.sink                       tick,
	gpm_result_if.source                   result
);
	import gpm_pkg::*;

	cfg_t  cfg;
	item_t item_s1;
	logic  valid_s1;
	logic  take;

	gpm_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	gpm_sequencer u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.tick     (tick),
		.take     (take),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	gpm_emitter u_emit (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1),
		.take     (take),
		.result   (result)
	);

`ifndef SYNTH
	// Only a quad tick can be waiting to send its second triangle.
	a_sub_after_first: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && item_s1.sub) |-> (item_s1.kind == KIND_TRIANGLE))
		else $error("second triangle word without a first");

	// A vertex word is always the only word of its tick and has no corners.
	a_vertex_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && (result.kind == KIND_VERTEX)) |->
		(result.last && !result.pass_end && (result.corner_a == '0) &&
		(result.corner_b == '0) && (result.corner_c == '0)))
		else $error("malformed vertex word");

	// End of pass is flagged only on the closing word of a quad tick.
	a_pass_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.pass_end) |->
		(result.last && (result.kind == KIND_TRIANGLE)))
		else $error("pass end on a non-final word");
`endif

endmodule

/* rtl/core/gpm_cfg_regs.sv */
// Configuration register file with reset values and side clamping.
// Depends on gpm_pkg.
module gpm_cfg_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic [gpm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [gpm_pkg::CFG_DATA_W-1:0] cfg_data,
	output gpm_pkg::cfg_t               cfg
);
	import gpm_pkg::*;

	logic [SIDE_W-1:0] grid_columns_q;
	logic [SIDE_W-1:0] grid_rows_q;
	logic [HALF_W-1:0] half_width_q;
	logic [HALF_W-1:0] half_height_q;
	logic [STEP_W-1:0] step_x_q;
	logic [STEP_W-1:0] step_y_q;
	logic [STEP_W-1:0] step_u_q;
	logic [STEP_W-1:0] step_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_columns_q <= RST_GRID_COLUMNS;
			grid_rows_q    <= RST_GRID_ROWS;
			half_width_q   <= RST_HALF_WIDTH;
			half_height_q  <= RST_HALF_HEIGHT;
			step_x_q       <= RST_STEP_X;
			step_y_q       <= RST_STEP_Y;
			step_u_q       <= RST_STEP_U;
			step_v_q       <= RST_STEP_V;
		end else if (cfg_wr_en) begin
			case (cfg_reg_t'(cfg_index))
				REG_GRID_COLUMNS: grid_columns_q <= cfg_data[SIDE_W-1:0];
				REG_GRID_ROWS:    grid_rows_q    <= cfg_data[SIDE_W-1:0];
				REG_HALF_WIDTH:   half_width_q   <= cfg_data[HALF_W-1:0];
				REG_HALF_HEIGHT:  half_height_q  <= cfg_data[HALF_W-1:0];
				REG_STEP_X:       step_x_q       <= cfg_data[STEP_W-1:0];
				REG_STEP_Y:       step_y_q       <= cfg_data[STEP_W-1:0];
				REG_STEP_U:       step_u_q       <= cfg_data[STEP_W-1:0];
				REG_STEP_V:       step_v_q       <= cfg_data[STEP_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		cfg.cols        = eff_side(grid_columns_q);
		cfg.rows        = eff_side(grid_rows_q);
		cfg.half_width  = half_width_q;
		cfg.half_height = half_height_q;
		cfg.step_x      = step_x_q;
		cfg.step_y      = step_y_q;
		cfg.step_u      = step_u_q;
		cfg.step_v      = step_v_q;
	end

endmodule

/* rtl/core/gpm_sequencer.sv */
// Grid walk state (phase, row, column, row base) and the stage-1 tick register.
// Depends on gpm_pkg and gpm_tick_if.
module gpm_sequencer (
	input  logic              clk,
	input  logic              arst_n,
	input  gpm_pkg::cfg_t     cfg,
	gpm_tick_if.sink          tick,
	input  logic              take,
	output logic              valid_s1,
	output gpm_pkg::item_t    item_s1
);
	import gpm_pkg::*;

	logic               phase_q;
	logic [COUNT_W-1:0] row_q;
	logic [COUNT_W-1:0] col_q;
	logic [INDEX_W-1:0] base_q;

	logic               cur_phase, nxt_phase;
	logic [COUNT_W-1:0] cur_row, nxt_row;
	logic [COUNT_W-1:0] cur_col, nxt_col;
	logic [INDEX_W-1:0] cur_base, nxt_base, base_add;
	logic [SIDE_W-1:0]  col_inc, row_inc;
	logic               row_end, pass_end;
	logic               done, accept;

	// The stage retires once its last word has moved to the output register.
	assign done   = take && ((item_s1.kind == KIND_VERTEX) || item_s1.sub);
	assign tick.ready = !valid_s1 || done;
	assign accept = tick.valid && tick.ready;

	always_comb begin
		cur_phase = tick.restart ? KIND_VERTEX : phase_q;
		cur_row   = tick.restart ? '0 : row_q;
		cur_col   = tick.restart ? '0 : col_q;
		cur_base  = tick.restart ? '0 : base_q;

		col_inc  = SIDE_W'(cur_col) + SIDE_W'(1);
		row_inc  = SIDE_W'(cur_row) + SIDE_W'(1);
		base_add = cur_base + INDEX_W'(cfg.cols);
		row_end  = col_inc >= (cfg.cols - SIDE_W'(1));
		pass_end = row_end && (row_inc >= (cfg.rows - SIDE_W'(1)));

		nxt_phase = cur_phase;
		nxt_row   = cur_row;
		nxt_col   = cur_col;
		nxt_base  = cur_base;

		if (cur_phase == KIND_VERTEX) begin
			if (col_inc >= cfg.cols) begin
				nxt_col = '0;
				if (row_inc >= cfg.rows) begin
					nxt_phase = KIND_TRIANGLE;
					nxt_row   = '0;
					nxt_base  = '0;
				end else begin
					nxt_row  = row_inc[COUNT_W-1:0];
					nxt_base = base_add;
				end
			end else begin
				nxt_col = col_inc[COUNT_W-1:0];
			end
		end else begin
			if (pass_end) begin
				nxt_phase = KIND_VERTEX;
				nxt_row   = '0;
				nxt_col   = '0;
				nxt_base  = '0;
			end else if (row_end) begin
				nxt_col  = '0;
				nxt_row  = row_inc[COUNT_W-1:0];
				nxt_base = base_add;
			end else begin
				nxt_col = col_inc[COUNT_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= KIND_VERTEX;
			row_q    <= '0;
			col_q    <= '0;
			base_q   <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (accept) begin
				phase_q  <= nxt_phase;
				row_q    <= nxt_row;
				col_q    <= nxt_col;
				base_q   <= nxt_base;
				valid_s1 <= 1'b1;
			end else if (done) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.kind     <= cur_phase;
			item_s1.col      <= cur_col;
			item_s1.row      <= cur_row;
			item_s1.base     <= cur_base;
			item_s1.pass_end <= (cur_phase == KIND_TRIANGLE) && pass_end;
			item_s1.sub      <= 1'b0;
		end else if (take) begin
			item_s1.sub <= 1'b1;
		end
	end

endmodule

/* rtl/core/gpm_emitter.sv */
// Vertex and triangle word datapath feeding the registered result channel.
// Depends on gpm_pkg and gpm_result_if.
module gpm_emitter (
	input  logic              clk,
	input  logic              arst_n,
	input  gpm_pkg::cfg_t     cfg,
	input  logic              valid_s1,
	input  gpm_pkg::item_t    item_s1,
	output logic              take,
	gpm_result_if.source      result
);
	import gpm_pkg::*;

	localparam int PROD_W = COUNT_W + STEP_W;
	localparam int WIDE_W = PROD_W + 2;

	function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [WIDE_W-1:0] v);
		logic signed [POS_W-1:0] r;
		if (v > WIDE_W'(32767)) begin
			r = 16'sh7FFF;
		end else if (v < -WIDE_W'(32768)) begin
			r = 16'sh8000;
		end else begin
			r = v[POS_W-1:0];
		end
		return r;
	endfunction

	function automatic logic [TEX_W-1:0] sat_tex(input logic [PROD_W-1:0] v);
		return (v > PROD_W'(TEX_ONE)) ? TEX_ONE : v[TEX_W-1:0];
	endfunction

	logic [PROD_W-1:0]        prod_x, prod_y, prod_u, prod_v;
	logic signed [WIDE_W-1:0] x_wide, y_wide;
	logic [INDEX_W-1:0]       top, bot, topn, botn;
	result_t                  nxt, out_q;
	logic                     out_valid_q;

	assign take = valid_s1 && (!out_valid_q || result.ready);

	always_comb begin
		prod_x = PROD_W'(item_s1.col) * PROD_W'(cfg.step_x);
		prod_y = PROD_W'(item_s1.row) * PROD_W'(cfg.step_y);
		prod_u = PROD_W'(item_s1.col) * PROD_W'(cfg.step_u);
		prod_v = PROD_W'(item_s1.row) * PROD_W'(cfg.step_v);
		x_wide = $signed(WIDE_W'(prod_x)) - $signed(WIDE_W'(cfg.half_width));
		y_wide = $signed(WIDE_W'(cfg.half_height)) - $signed(WIDE_W'(prod_y));

		top  = item_s1.base + INDEX_W'(item_s1.col);
		bot  = top + INDEX_W'(cfg.cols);
		topn = top + INDEX_W'(1);
		botn = bot + INDEX_W'(1);

		nxt = '0;
		nxt.kind = item_s1.kind;
		if (item_s1.kind == KIND_VERTEX) begin
			nxt.pos_x = sat_pos(x_wide);
			nxt.pos_y = sat_pos(y_wide);
			nxt.tex_u = sat_tex(prod_u);
			nxt.tex_v = sat_tex(prod_v);
			nxt.last  = 1'b1;
		end else if (!item_s1.sub) begin
			nxt.corner_a = top;
			nxt.corner_b = bot;
			nxt.corner_c = topn;
		end else begin
			nxt.corner_a = bot;
			nxt.corner_b = botn;
			nxt.corner_c = topn;
			nxt.pass_end = item_s1.pass_end;
			nxt.last     = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_q <= nxt;
		end
	end

	assign result.valid    = out_valid_q;
	assign result.kind     = out_q.kind;
	assign result.pos_x    = out_q.pos_x;
	assign result.pos_y    = out_q.pos_y;
	assign result.tex_u    = out_q.tex_u;
	assign result.tex_v    = out_q.tex_v;
	assign result.corner_a = out_q.corner_a;
	assign result.corner_b = out_q.corner_b;
	assign result.corner_c = out_q.corner_c;
	assign result.pass_end = out_q.pass_end;
	assign result.last     = out_q.last;

endmodule
